@@ rtl/oasc_pkg.sv @@
`default_nettype none

package oasc_pkg;

    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int HITS_W     = 8;
    localparam int RATE_W     = 15;
    localparam int YAW_W      = 16;
    localparam int MAG_W      = YAW_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [HITS_W-1:0] HIT_MAX = 8'd255;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_HITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_MAX  = 3'd5;

    // register reset values
    localparam logic [TIME_W-1:0]  RST_RUN_START     = 32'd0;
    localparam logic [DELAY_W-1:0] RST_STARTUP_DELAY = 16'd1000;
    localparam logic [HITS_W-1:0]  RST_CONFIRM_HITS  = 8'd2;
    localparam logic [RATE_W-1:0]  RST_RATE_LIMIT    = 15'd655;
    localparam logic [DELAY_W-1:0] RST_WAIT_MAX      = 16'd300;
    localparam logic [DELAY_W-1:0] RST_APPROACH_MAX  = 16'd20000;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_CRUISE  = 3'd1,
        PH_CREEP   = 3'd2,
        PH_STOPPED = 3'd3,
        PH_TIMEOUT = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        DRV_IDLE   = 2'd0,
        DRV_CRUISE = 2'd1,
        DRV_CREEP  = 2'd2,
        DRV_BRAKE  = 2'd3
    } drive_t;

    typedef struct packed {
        logic [TIME_W-1:0]  run_start_ms;
        logic [DELAY_W-1:0] start_wait_ms;
        logic [HITS_W-1:0]  stop_confirm_hits;
        logic [RATE_W-1:0]  straight_rate_limit;
        logic [DELAY_W-1:0] straight_wait_max_ms;
        logic [DELAY_W-1:0] approach_max_ms;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [HITS_W-1:0]  hit_count;
        logic [TIME_W-1:0]  drive_start_time;
        logic [TIME_W-1:0]  confirm_start_time;
        logic               confirm_active;
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]       time_ms;
        logic signed [YAW_W-1:0] yaw_rate;
        logic                    front_too_close;
        logic                    front_below_slow;
        logic                    front_below_stop;
    } tick_t;

    typedef struct packed {
        phase_t phase;
        drive_t drive_cmd;
        logic   start_drive;
        logic   stop_forced;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/obstacle_approach_stop_control.sv @@
// Obstacle approach and stop control, one control tick per transfer.
// Input channel (in_valid/in_ready) carries time_ms, yaw_rate and the three
// front flags. Output channel (out_valid/out_ready) returns exactly one
// result per tick: phase, drive_cmd, start_drive, stop_forced.
// Config: cfg_we/cfg_index/cfg_wdata write one register per cycle; write
// only while no tick is in flight. Unknown indexes are ignored.
// Path: a taken tick sits in the input register, is evaluated and lands in
// the result register once it is free or draining, and out_valid goes high.
// Throughput: one tick per cycle while out_ready holds. The whole evaluation
// (three 32-bit subtract-and-compares, yaw magnitude, hit counter) is one
// combinational pass between the input register and the result register;
// the state registers update in the same cycle the result is loaded.
// Reset: phase goes to wait, counters and confirm window clear, config
// registers take their defaults, both pipeline registers are empty.
// Stall: while out_ready is low a held result keeps the input register
// full and in_ready drops; nothing is lost or repeated.
`default_nettype none

module obstacle_approach_stop_control (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_we,
    input  wire  [oasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [oasc_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [31:0] time_ms,
    input  wire  signed [15:0] yaw_rate,
    input  wire         front_too_close,
    input  wire         front_below_slow,
    input  wire         front_below_stop,

    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  phase,
    output logic [1:0]  drive_cmd,
    output logic        start_drive,
    output logic        stop_forced
);

    oasc_pkg::cfg_t    cfg_reg;
    oasc_pkg::state_t  state_reg;
    oasc_pkg::state_t  state_next;
    oasc_pkg::tick_t   tick_reg;
    oasc_pkg::result_t res_next;
    oasc_pkg::result_t res_reg;
    logic              tick_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_xfer;

    // tick moves to the result register when that register is free or draining
    assign advance   = tick_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !tick_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_start_ms         <= oasc_pkg::RST_RUN_START;
            cfg_reg.start_wait_ms        <= oasc_pkg::RST_STARTUP_DELAY;
            cfg_reg.stop_confirm_hits    <= oasc_pkg::RST_CONFIRM_HITS;
            cfg_reg.straight_rate_limit  <= oasc_pkg::RST_RATE_LIMIT;
            cfg_reg.straight_wait_max_ms <= oasc_pkg::RST_WAIT_MAX;
            cfg_reg.approach_max_ms      <= oasc_pkg::RST_APPROACH_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                oasc_pkg::CFG_RUN_START:
                    cfg_reg.run_start_ms <= cfg_wdata;
                oasc_pkg::CFG_STARTUP_DELAY:
                    cfg_reg.start_wait_ms <= cfg_wdata[oasc_pkg::DELAY_W-1:0];
                oasc_pkg::CFG_CONFIRM_HITS:
                    cfg_reg.stop_confirm_hits <= cfg_wdata[oasc_pkg::HITS_W-1:0];
                oasc_pkg::CFG_RATE_LIMIT:
                    cfg_reg.straight_rate_limit <= cfg_wdata[oasc_pkg::RATE_W-1:0];
                oasc_pkg::CFG_WAIT_MAX:
                    cfg_reg.straight_wait_max_ms <= cfg_wdata[oasc_pkg::DELAY_W-1:0];
                oasc_pkg::CFG_APPROACH_MAX:
                    cfg_reg.approach_max_ms <= cfg_wdata[oasc_pkg::DELAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control: valid flags and sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg               <= 1'b0;
            out_valid_reg                <= 1'b0;
            state_reg.phase              <= oasc_pkg::PH_WAIT;
            state_reg.hit_count          <= '0;
            state_reg.drive_start_time   <= '0;
            state_reg.confirm_start_time <= '0;
            state_reg.confirm_active     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                tick_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tick_reg.time_ms          <= time_ms;
            tick_reg.yaw_rate         <= yaw_rate;
            tick_reg.front_too_close  <= front_too_close;
            tick_reg.front_below_slow <= front_below_slow;
            tick_reg.front_below_stop <= front_below_stop;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    oasc_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign out_valid   = out_valid_reg;
    assign phase       = res_reg.phase;
    assign drive_cmd   = res_reg.drive_cmd;
    assign start_drive = res_reg.start_drive;
    assign stop_forced = res_reg.stop_forced;

endmodule

`default_nettype wire

@@ rtl/oasc_step.sv @@
`default_nettype none

// One control tick: next state and result from current state and the tick.
module oasc_step (
    input  var oasc_pkg::state_t  cur,
    input  var oasc_pkg::cfg_t    cfg,
    input  var oasc_pkg::tick_t   tick,
    output oasc_pkg::state_t      nxt,
    output oasc_pkg::result_t     res
);

    logic [oasc_pkg::TIME_W-1:0] since_run;
    logic [oasc_pkg::TIME_W-1:0] since_drive;
    logic [oasc_pkg::TIME_W-1:0] since_confirm;
    logic [oasc_pkg::TIME_W-1:0] confirm_start;
    logic [oasc_pkg::MAG_W-1:0]  yaw_mag;
    logic [oasc_pkg::HITS_W-1:0] hits;
    logic                        wait_done;
    logic                        stop;
    logic                        forced;

    // |yaw|, most negative value gives 32768 (never straight)
    always_comb
    begin
        if (tick.yaw_rate[oasc_pkg::YAW_W-1])
        begin
            yaw_mag = oasc_pkg::MAG_W'(17'h10000)
                      - {1'b0, $unsigned(tick.yaw_rate)};
        end
        else
        begin
            yaw_mag = {1'b0, $unsigned(tick.yaw_rate)};
        end
    end

    assign since_run = tick.time_ms - cfg.run_start_ms;
    assign wait_done = (cur.phase == oasc_pkg::PH_WAIT)
                       && (since_run > {16'd0, cfg.start_wait_ms});

    always_comb
    begin
        nxt             = cur;
        res.phase       = cur.phase;
        res.drive_cmd   = oasc_pkg::DRV_IDLE;
        res.start_drive = 1'b0;
        res.stop_forced = 1'b0;
        stop            = 1'b0;
        forced          = 1'b0;
        hits            = cur.hit_count;
        confirm_start   = cur.confirm_start_time;
        since_confirm   = '0;

        if (wait_done)
        begin
            nxt.phase            = oasc_pkg::PH_CRUISE;
            nxt.drive_start_time = tick.time_ms;
            res.start_drive      = 1'b1;
        end

        since_drive = tick.time_ms - nxt.drive_start_time;

        if (nxt.phase == oasc_pkg::PH_CRUISE || nxt.phase == oasc_pkg::PH_CREEP)
        begin
            if (nxt.phase == oasc_pkg::PH_CRUISE && tick.front_below_slow)
            begin
                nxt.phase = oasc_pkg::PH_CREEP;
            end

            if (tick.front_too_close)
            begin
                stop   = 1'b1;
                forced = 1'b1;
            end
            else
            begin
                if (tick.front_below_stop)
                begin
                    if (cur.hit_count < oasc_pkg::HIT_MAX)
                    begin
                        hits = cur.hit_count + 8'd1;
                    end
                end
                else
                begin
                    hits = '0;
                end
                nxt.hit_count = hits;

                if (hits >= cfg.stop_confirm_hits)
                begin
                    if (!cur.confirm_active)
                    begin
                        confirm_start = tick.time_ms;
                    end
                    nxt.confirm_active     = 1'b1;
                    nxt.confirm_start_time = confirm_start;
                    since_confirm          = tick.time_ms - confirm_start;
                    if (yaw_mag < {2'b00, cfg.straight_rate_limit})
                    begin
                        stop = 1'b1;
                    end
                    else if (since_confirm > {16'd0, cfg.straight_wait_max_ms})
                    begin
                        stop   = 1'b1;
                        forced = 1'b1;
                    end
                end
                else
                begin
                    nxt.confirm_active = 1'b0;
                end
            end

            if (stop)
            begin
                nxt.phase     = oasc_pkg::PH_STOPPED;
                res.drive_cmd = oasc_pkg::DRV_BRAKE;
            end
            else if (since_drive > {16'd0, cfg.approach_max_ms})
            begin
                nxt.phase     = oasc_pkg::PH_TIMEOUT;
                res.drive_cmd = oasc_pkg::DRV_BRAKE;
            end
            else if (nxt.phase == oasc_pkg::PH_CREEP)
            begin
                res.drive_cmd = oasc_pkg::DRV_CREEP;
            end
            else
            begin
                res.drive_cmd = oasc_pkg::DRV_CRUISE;
            end
            res.stop_forced = forced;
        end

        res.phase = nxt.phase;
    end

endmodule

`default_nettype wire

@@ test/tb_obstacle_approach_stop_control.sv @@
`default_nettype none

// Tracks the register file and the approach sequencer state, and holds the
// results due from the block in transfer order.
class approach_checker;
    oasc_pkg::cfg_t    regs;
    oasc_pkg::phase_t  cur_phase;
    logic [7:0]        hit_run;
    logic [31:0]       drive_t0;
    logic [31:0]       confirm_t0;
    logic              confirming;
    oasc_pkg::result_t due_results[$];
    int                mismatches;

    function new();
        regs.run_start_ms         = oasc_pkg::RST_RUN_START;
        regs.start_wait_ms        = oasc_pkg::RST_STARTUP_DELAY;
        regs.stop_confirm_hits    = oasc_pkg::RST_CONFIRM_HITS;
        regs.straight_rate_limit  = oasc_pkg::RST_RATE_LIMIT;
        regs.straight_wait_max_ms = oasc_pkg::RST_WAIT_MAX;
        regs.approach_max_ms      = oasc_pkg::RST_APPROACH_MAX;
        cur_phase  = oasc_pkg::PH_WAIT;
        hit_run    = '0;
        drive_t0   = '0;
        confirm_t0 = '0;
        confirming = 1'b0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            oasc_pkg::CFG_RUN_START:     regs.run_start_ms         = data;
            oasc_pkg::CFG_STARTUP_DELAY: regs.start_wait_ms        = data[15:0];
            oasc_pkg::CFG_CONFIRM_HITS:  regs.stop_confirm_hits    = data[7:0];
            oasc_pkg::CFG_RATE_LIMIT:    regs.straight_rate_limit  = data[14:0];
            oasc_pkg::CFG_WAIT_MAX:      regs.straight_wait_max_ms = data[15:0];
            oasc_pkg::CFG_APPROACH_MAX:  regs.approach_max_ms      = data[15:0];
            default: ;
        endcase
    endfunction

    function void note_tick(oasc_pkg::tick_t t);
        oasc_pkg::result_t r;
        logic [15:0] yaw_bits;
        logic [16:0] yaw_mag;
        logic [31:0] since_run;
        logic [31:0] since_confirm;
        logic [31:0] since_drive;
        logic        halt;

        r.phase       = cur_phase;
        r.drive_cmd   = oasc_pkg::DRV_IDLE;
        r.start_drive = 1'b0;
        r.stop_forced = 1'b0;

        // -32768 maps to 32768, out of reach of any 15-bit limit
        yaw_bits = t.yaw_rate;
        yaw_mag  = yaw_bits[15] ? (17'h10000 - yaw_bits) : {1'b0, yaw_bits};

        since_run = t.time_ms - regs.run_start_ms;
        if (cur_phase == oasc_pkg::PH_WAIT && since_run > regs.start_wait_ms)
        begin
            drive_t0      = t.time_ms;
            cur_phase     = oasc_pkg::PH_CRUISE;
            r.start_drive = 1'b1;
        end

        // the tick that leaves wait falls through into the moving phases
        if (cur_phase == oasc_pkg::PH_CRUISE || cur_phase == oasc_pkg::PH_CREEP)
        begin
            halt = 1'b0;
            if (cur_phase == oasc_pkg::PH_CRUISE && t.front_below_slow)
                cur_phase = oasc_pkg::PH_CREEP;

            if (t.front_too_close)
            begin
                halt          = 1'b1;
                r.stop_forced = 1'b1;
            end
            else
            begin
                if (t.front_below_stop)
                begin
                    if (hit_run != oasc_pkg::HIT_MAX)
                        hit_run = hit_run + 8'd1;
                end
                else
                    hit_run = '0;

                if (hit_run >= regs.stop_confirm_hits)
                begin
                    if (!confirming)
                    begin
                        confirming = 1'b1;
                        confirm_t0 = t.time_ms;
                    end
                    since_confirm = t.time_ms - confirm_t0;
                    if (yaw_mag < regs.straight_rate_limit)
                        halt = 1'b1;
                    else if (since_confirm > regs.straight_wait_max_ms)
                    begin
                        halt          = 1'b1;
                        r.stop_forced = 1'b1;
                    end
                end
                else
                    confirming = 1'b0;
            end

            since_drive = t.time_ms - drive_t0;
            if (halt)
            begin
                cur_phase   = oasc_pkg::PH_STOPPED;
                r.drive_cmd = oasc_pkg::DRV_BRAKE;
            end
            else if (since_drive > regs.approach_max_ms)
            begin
                cur_phase   = oasc_pkg::PH_TIMEOUT;
                r.drive_cmd = oasc_pkg::DRV_BRAKE;
            end
            else if (cur_phase == oasc_pkg::PH_CREEP)
                r.drive_cmd = oasc_pkg::DRV_CREEP;
            else
                r.drive_cmd = oasc_pkg::DRV_CRUISE;
        end

        r.phase = cur_phase;
        due_results.push_back(r);
    endfunction

    function void compare(string name, logic [2:0] want, logic [2:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    function void check_result(logic [2:0] ph, logic [1:0] drv, logic sd, logic sf);
        oasc_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: result with nothing due: phase %0d drive %0d start %0d forced %0d",
                     $time, ph, drv, sd, sf);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        compare("phase", want.phase, ph);
        compare("drive_cmd", want.drive_cmd, drv);
        compare("start_drive", want.start_drive, sd);
        compare("stop_forced", want.stop_forced, sf);
    endfunction

    function int pending();
        return due_results.size();
    endfunction
endclass

module tb_obstacle_approach_stop_control;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the last register; writes there must change nothing
    localparam logic [oasc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [oasc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [31:0]       cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [31:0]       time_ms = '0;
    logic signed [15:0] yaw_rate = '0;
    logic              front_too_close = 1'b0;
    logic              front_below_slow = 1'b0;
    logic              front_below_stop = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        phase;
    logic [1:0]        drive_cmd;
    logic              start_drive;
    logic              stop_forced;

    approach_checker sb;

    // idling knobs: chance in percent of starting a burst on each side, and a
    // switch that turns all idling off for the tail of the run
    int gap_pct = 0;
    int stall_pct = 0;
    bit steady_tail = 1'b0;
    int stall_left = 0;
    logic ready_next;

    obstacle_approach_stop_control DUT (.*);

    always #5 clk = ~clk;

    // Both channels are sampled at the falling edge: inputs only move at the
    // rising edge and outputs only settle after it, so what is seen here is
    // exactly what the next rising edge will transfer.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_tick(oasc_pkg::tick_t'{time_ms, yaw_rate, front_too_close,
                                               front_below_slow, front_below_stop});
            if (out_valid && out_ready)
                sb.check_result(phase, drive_cmd, start_drive, stop_forced);
        end
    end

    // Receiver side: out_ready drops in random stall bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            ready_next = 1'b0;
        end
        else if (!steady_tail && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            ready_next = 1'b0;
        end
        else
            ready_next = 1'b1;
        out_ready <= ready_next;
    end

    // One tick transfer. Called and returning right after a rising edge; when
    // no gap is taken, valid simply stays high into the next transfer.
    task automatic send_tick(input logic [31:0] t_ms, input logic [15:0] yaw,
                             input logic near_flag, input logic below_slow,
                             input logic below_stop);
        bit taken;
        if (!steady_tail && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        time_ms          <= t_ms;
        yaw_rate         <= yaw;
        front_too_close  <= near_flag;
        front_below_slow <= below_slow;
        front_below_stop <= below_stop;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Register write, only once every due result has come back. Every tick
    // yields a result, so an empty queue means the block is idle.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] run_base;
        logic [31:0] now_ms;
        logic [15:0] yaw_pick;
        int ending;
        int waited;

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct   = 30;
        stall_pct = 30;

        // Reset values: run start 0, startup delay 1000. Time 1000 is still
        // inside the window; the flags mean nothing while waiting.
        send_tick(32'd0, 16'h7FFF, 1'b1, 1'b1, 1'b1);
        send_tick(32'd1000, 16'h8000, 1'b0, 1'b0, 1'b0);

        // Zero delay at the top of the time range: only that exact time waits.
        cfg_write(oasc_pkg::CFG_RUN_START, 32'hFFFF_FFFF);
        cfg_write(oasc_pkg::CFG_STARTUP_DELAY, 32'd0);
        cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_HI, 32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0, 1'b1);

        // Longest delay, window placed across the 32-bit wrap. Confirm needs
        // a full hit counter, nothing is ever straight, and both time limits
        // sit at their maximum so the approach can run for a long time.
        run_base = 32'hFFFF_0000 | $urandom_range(1, 65535);
        cfg_write(oasc_pkg::CFG_RUN_START, run_base);
        cfg_write(oasc_pkg::CFG_STARTUP_DELAY, 32'd65535);
        cfg_write(oasc_pkg::CFG_CONFIRM_HITS, 32'd255);
        cfg_write(oasc_pkg::CFG_RATE_LIMIT, 32'd0);
        cfg_write(oasc_pkg::CFG_WAIT_MAX, 32'd65535);
        cfg_write(oasc_pkg::CFG_APPROACH_MAX, 32'd65535);
        send_tick(run_base, 16'($urandom), 1'b1, 1'b1, 1'b1);
        send_tick(run_base + 32'd65535, 16'($urandom), 1'b0, 1'b0, 1'b0);
        repeat (60)
            send_tick(run_base + $urandom_range(0, 65535), 16'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));

        // One past the window: cruise starts and this same tick is evaluated
        // as a cruise tick.
        now_ms = run_base + 32'd65536;
        send_tick(now_ms, 16'($urandom), 1'b0, 1'b0, 1'($urandom));

        // Cruise with time moving forward in small steps. Hits come and go but
        // never reach 255 in a row. First a stretch without any idling.
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < 60; i++)
        begin
            if (i == 30)
            begin
                gap_pct   = 50;
                stall_pct = 50;
            end
            now_ms = now_ms + $urandom_range(0, 40);
            send_tick(now_ms, 16'($urandom), 1'b0, 1'b0, 1'($urandom));
        end

        // Zero confirm count: every tick confirms. A steep yaw keeps it from
        // counting as straight, so the confirm window just stays open.
        gap_pct   = 20;
        stall_pct = 40;
        cfg_write(oasc_pkg::CFG_CONFIRM_HITS, 32'd0);
        cfg_write(oasc_pkg::CFG_RATE_LIMIT, 32'd16384);
        send_tick(now_ms, 16'd16384, 1'b0, 1'b0, 1'b0);
        repeat (15)
        begin
            now_ms = now_ms + $urandom_range(0, 40);
            send_tick(now_ms, 16'($urandom_range(16384, 32767)), 1'b0, 1'b0,
                      1'($urandom));
        end

        // Small confirm counts: the window opens and closes repeatedly.
        cfg_write(oasc_pkg::CFG_CONFIRM_HITS, 32'd1);
        repeat (30)
        begin
            now_ms = now_ms + $urandom_range(0, 40);
            yaw_pick = 16'($urandom_range(16384, 32767));
            if ($urandom_range(0, 1))
                yaw_pick = -yaw_pick;
            if ($urandom_range(0, 15) == 0)
                yaw_pick = 16'h8000;
            send_tick(now_ms, yaw_pick, 1'b0, 1'b0, $urandom_range(0, 9) < 7);
        end
        cfg_write(oasc_pkg::CFG_CONFIRM_HITS, $urandom_range(2, 6));
        repeat (70)
        begin
            now_ms = now_ms + $urandom_range(0, 40);
            yaw_pick = 16'($urandom_range(16384, 32767));
            if ($urandom_range(0, 1))
                yaw_pick = -yaw_pick;
            if ($urandom_range(0, 15) == 0)
                yaw_pick = 16'h8000;
            send_tick(now_ms, yaw_pick, 1'b0, 1'b0, $urandom_range(0, 9) < 7);
        end

        // Drop to creep, then push the hit counter into saturation: the
        // limit is its maximum, so the window opens and stays open.
        gap_pct   = 40;
        stall_pct = 20;
        cfg_write(oasc_pkg::CFG_CONFIRM_HITS, 32'd255);
        cfg_write(oasc_pkg::CFG_RATE_LIMIT, 32'd0);
        now_ms = now_ms + $urandom_range(0, 40);
        send_tick(now_ms, 16'($urandom), 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 300; i++)
        begin
            if (i == 250)
                steady_tail = 1'b1;
            now_ms = now_ms + $urandom_range(0, 40);
            send_tick(now_ms, 16'($urandom), 1'b0, 1'($urandom),
                      (i < 20) ? 1'($urandom) : 1'b1);
        end

        // Widest straight limit: -32768 and -32767 are still not straight.
        cfg_write(oasc_pkg::CFG_RATE_LIMIT, 32'd32767);
        send_tick(now_ms, 16'h8000, 1'b0, 1'b1, 1'b1);
        send_tick(now_ms, 16'h8001, 1'b0, 1'b0, 1'b1);

        // Only one way to leave the approach per run; the seed picks it.
        ending = $urandom_range(0, 3);
        case (ending)
            0:
                send_tick(now_ms, 16'($urandom), 1'b1, 1'($urandom), 1'($urandom));
            1:
            begin
                yaw_pick = 16'($urandom_range(0, 32766));
                if ($urandom_range(0, 1))
                    yaw_pick = -yaw_pick;
                send_tick(now_ms, yaw_pick, 1'b0, 1'($urandom), 1'b1);
            end
            2:
            begin
                cfg_write(oasc_pkg::CFG_WAIT_MAX, 32'd0);
                send_tick(now_ms + 32'd1, 16'h8000, 1'b0, 1'($urandom), 1'b1);
            end
            default:
            begin
                cfg_write(oasc_pkg::CFG_APPROACH_MAX, 32'd0);
                send_tick(now_ms + 32'd1, 16'h8000, 1'b0, 1'($urandom), 1'b0);
            end
        endcase

        // Final phase holds whatever comes in.
        repeat (6)
            send_tick($urandom, 16'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom));

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest run with every burst at its longest.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
rtl/oasc_pkg.sv
rtl/oasc_step.sv
rtl/obstacle_approach_stop_control.sv
test/tb_obstacle_approach_stop_control.sv
